[design/pcpd_pkg.sv]
// Shared types and constants of the PCI configuration port decoder.
`default_nettype none

package pcpd_pkg;

    typedef enum logic [2:0] {
        KIND_UNCLAIMED  = 3'd0,
        KIND_REG_RD     = 3'd1,
        KIND_REG_WR     = 3'd2,
        KIND_CFG_RD     = 3'd3,
        KIND_CFG_WR     = 3'd4,
        KIND_MISALIGNED = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        SIZE_BYTE  = 2'd0,
        SIZE_WORD  = 2'd1,
        SIZE_DWORD = 2'd2,
        SIZE_BAD   = 2'd3
    } t_size;

    localparam logic [15:0] PORT_ADDR   = 16'h0CF8;
    localparam logic [15:0] PORT_FWD    = 16'h0CFA;
    localparam logic [15:0] PORT_MECH   = 16'h0CFB;
    localparam logic [15:0] PORT_DATA   = 16'h0CFC;
    localparam logic [15:0] PORT_WINDOW = 16'hC000;
    localparam logic [7:0]  KEY_MASK    = 8'hF0;

    // Classified access, front to back
    typedef struct packed {
        t_kind       kind;
        logic [31:0] read_data;
        logic [7:0]  bus;
        logic [4:0]  dev;
        logic [2:0]  fn;
        logic [5:0]  dreg;
        t_size       size;
        logic [1:0]  off;
        logic [31:0] data;
    } t_cmd;

    // Result item as presented at the output
    typedef struct packed {
        t_kind       kind;
        logic [31:0] read_data;
        logic [7:0]  bus;
        logic [4:0]  dev;
        logic [2:0]  fn;
        logic [5:0]  dreg;
        logic [3:0]  be;
        logic [31:0] lane_data;
    } t_result;

endpackage

`default_nettype wire

[design/pcpd_front.sv]
// Front end: register file and classification of each I/O access.
`default_nettype none

module pcpd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_command,
    input  wire logic [15:0]   i_port,
    input  wire logic [1:0]    i_access_size,
    input  wire logic [31:0]   i_write_data,
    input  wire logic          i_q_full,
    output logic               o_push,
    output pcpd_pkg::t_cmd     o_cmd
);
    import pcpd_pkg::*;

    logic        r_mech_one, n_mech_one;
    logic [22:0] r_addr, n_addr;
    logic [7:0]  r_efb, n_efb;
    logic [7:0]  r_fwd_bus, n_fwd_bus;

    t_cmd        cmd;
    t_size       size;
    logic [31:0] data;
    logic        cfg_hit;
    logic [7:0]  cfg_bus;
    logic [4:0]  cfg_dev;
    logic [2:0]  cfg_fn;
    logic [5:0]  cfg_reg;
    logic        is_aligned;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_cmd   = cmd;

    always_comb begin
        size       = t_size'(i_access_size);
        data       = i_write_data;
        is_aligned = 1'b0;
        case (size)
            SIZE_BYTE: begin
                data       = {24'd0, i_write_data[7:0]};
                is_aligned = 1'b1;
            end
            SIZE_WORD: begin
                data       = {16'd0, i_write_data[15:0]};
                is_aligned = !i_port[0];
            end
            SIZE_DWORD: begin
                is_aligned = (i_port[1:0] == 2'd0);
            end
            default: begin
                is_aligned = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mech_one = r_mech_one;
        n_addr     = r_addr;
        n_efb      = r_efb;
        n_fwd_bus  = r_fwd_bus;
        cmd        = '0;
        cmd.kind   = KIND_UNCLAIMED;
        cfg_hit    = 1'b0;
        cfg_bus    = '0;
        cfg_dev    = '0;
        cfg_fn     = '0;
        cfg_reg    = '0;

        if (i_port == PORT_MECH && size == SIZE_BYTE) begin
            if (i_command) begin
                n_mech_one = data[0];
                cmd.kind   = KIND_REG_WR;
            end else begin
                cmd.kind      = KIND_REG_RD;
                cmd.read_data = {31'd0, r_mech_one};
            end
        end else if (r_mech_one) begin
            if (i_port == PORT_ADDR && size == SIZE_DWORD) begin
                if (i_command) begin
                    n_addr   = {data[31], data[23:16], data[15:8], data[7:2]};
                    cmd.kind = KIND_REG_WR;
                end else begin
                    cmd.kind      = KIND_REG_RD;
                    cmd.read_data = {r_addr[22], 7'd0, r_addr[21:14], r_addr[13:6],
                                     r_addr[5:0], 2'd0};
                end
            end else if (i_port[15:2] == PORT_DATA[15:2] && r_addr[22]) begin
                cfg_hit = 1'b1;
                cfg_bus = r_addr[21:14];
                cfg_dev = r_addr[13:9];
                cfg_fn  = r_addr[8:6];
                cfg_reg = r_addr[5:0];
            end
        end else begin
            if ((i_port == PORT_ADDR || i_port == PORT_FWD) && size == SIZE_BYTE) begin
                if (i_command) begin
                    if (i_port == PORT_ADDR) begin
                        n_efb = data[7:0];
                    end else begin
                        n_fwd_bus = data[7:0];
                    end
                    cmd.kind = KIND_REG_WR;
                end else begin
                    cmd.kind      = KIND_REG_RD;
                    cmd.read_data = {24'd0, (i_port == PORT_ADDR) ? r_efb : r_fwd_bus};
                end
            end else if (i_port[15:3] == PORT_ADDR[15:3]) begin
                cmd.kind = KIND_UNCLAIMED;
            end else if (i_port[15:12] == PORT_WINDOW[15:12] &&
                         (r_efb & KEY_MASK) != 8'd0) begin
                cfg_hit = 1'b1;
                cfg_bus = r_fwd_bus;
                cfg_dev = {1'b0, i_port[11:8]};
                cfg_fn  = r_efb[3:1];
                cfg_reg = i_port[7:2];
            end
        end

        if (cfg_hit) begin
            if (is_aligned) begin
                cmd.kind = i_command ? KIND_CFG_WR : KIND_CFG_RD;
                cmd.bus  = cfg_bus;
                cmd.dev  = cfg_dev;
                cmd.fn   = cfg_fn;
                cmd.dreg = cfg_reg;
                cmd.size = size;
                cmd.off  = i_port[1:0];
                cmd.data = data;
            end else begin
                cmd.kind = KIND_MISALIGNED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mech_one <= 1'b1;
            r_addr     <= '0;
            r_efb      <= '0;
            r_fwd_bus  <= '0;
        end else if (o_push) begin
            r_mech_one <= n_mech_one;
            r_addr     <= n_addr;
            r_efb      <= n_efb;
            r_fwd_bus  <= n_fwd_bus;
        end
    end

endmodule

`default_nettype wire

[design/pcpd_fifo.sv]
// Short queue of classified accesses between front and back.
`default_nettype none

module pcpd_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pcpd_pkg::t_cmd i_push_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output pcpd_pkg::t_cmd      o_head
);
    import pcpd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[design/pcpd_back.sv]
// Back end: byte-lane formatting and the output register.
`default_nettype none

module pcpd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_empty,
    input  wire pcpd_pkg::t_cmd i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output pcpd_pkg::t_result   o_result
);
    import pcpd_pkg::*;

    logic        r_valid;
    t_result     r_out, n_out;
    logic [3:0]  lanes;
    logic        is_cfg;

    assign o_pop    = !i_q_empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    always_comb begin
        case (i_head.size)
            SIZE_BYTE: lanes = 4'b0001;
            SIZE_WORD: lanes = 4'b0011;
            default:   lanes = 4'b1111;
        endcase
        is_cfg          = (i_head.kind == KIND_CFG_RD || i_head.kind == KIND_CFG_WR);
        n_out.kind      = i_head.kind;
        n_out.read_data = i_head.read_data;
        n_out.bus       = i_head.bus;
        n_out.dev       = i_head.dev;
        n_out.fn        = i_head.fn;
        n_out.dreg      = i_head.dreg;
        n_out.be        = is_cfg ? (lanes << i_head.off) : 4'd0;
        n_out.lane_data = (i_head.kind == KIND_CFG_WR) ?
                          (i_head.data << {i_head.off, 3'd0}) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[design/pci_config_port_decoder_core.sv]
// Top level of the PCI configuration port decoder (mechanisms one and two).
// One I/O access in, one result out. The front end decodes each access
// against the bridge registers (0xCFB mechanism select, 0xCF8 address or
// enable/function byte, 0xCFA forward bus) and updates them as it accepts;
// the back end builds byte enables and lane-shifted data and holds the
// result in an output register. A queue of QUEUE_DEPTH entries sits between
// them. Sustained rate is one access per cycle while i_ready stays high.
// The queue is written at the accepting edge; the output register, whose
// result shows at o_valid, loads from the queue head when it is empty or
// its held result is being taken by i_ready.
`default_nettype none

module pci_config_port_decoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_command,
    input  wire logic [15:0] i_port,
    input  wire logic [1:0]  i_access_size,
    input  wire logic [31:0] i_write_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_kind,
    output logic [31:0]      o_read_data,
    output logic [7:0]       o_bus_number,
    output logic [4:0]       o_device_number,
    output logic [2:0]       o_function_number,
    output logic [5:0]       o_dword_register,
    output logic [3:0]       o_byte_enable,
    output logic [31:0]      o_lane_data
);
    import pcpd_pkg::*;

    t_cmd    push_cmd, head_cmd;
    t_result result;
    logic    push, pop, q_full, q_empty;

    pcpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_port        (i_port),
        .i_access_size (i_access_size),
        .i_write_data  (i_write_data),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    pcpd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_empty     (q_empty),
        .o_head      (head_cmd)
    );

    pcpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head_cmd),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (result)
    );

    assign o_kind            = result.kind;
    assign o_read_data       = result.read_data;
    assign o_bus_number      = result.bus;
    assign o_device_number   = result.dev;
    assign o_function_number = result.fn;
    assign o_dword_register  = result.dreg;
    assign o_byte_enable     = result.be;
    assign o_lane_data       = result.lane_data;

endmodule

`default_nettype wire

[design/pcpd_checker.sv]
// Port-level checks of the decoder, bound to the top level.
`default_nettype none

module pcpd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_kind,
    input wire logic [31:0] o_read_data,
    input wire logic [7:0]  o_bus_number,
    input wire logic [3:0]  o_byte_enable,
    input wire logic [31:0] o_lane_data
);
    import pcpd_pkg::*;

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_misaligned_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_MISALIGNED) |->
        (o_byte_enable == 4'd0 && o_lane_data == 32'd0 && o_bus_number == 8'd0
         && o_read_data == 32'd0))
        else $error("misaligned result carries request fields");

    a_cfg_read_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_CFG_RD) |->
        (o_byte_enable != 4'd0 && o_lane_data == 32'd0))
        else $error("config read with bad lanes");

    a_reg_no_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_REG_RD || o_kind == KIND_REG_WR ||
                     o_kind == KIND_UNCLAIMED)) |->
        (o_byte_enable == 4'd0 && o_lane_data == 32'd0))
        else $error("non-config result drives byte lanes");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_kind) && $stable(o_lane_data)))
        else $error("stalled result changed");

endmodule

bind pci_config_port_decoder_core pcpd_checker u_pcpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_kind        (o_kind),
    .o_read_data   (o_read_data),
    .o_bus_number  (o_bus_number),
    .o_byte_enable (o_byte_enable),
    .o_lane_data   (o_lane_data)
);

`default_nettype wire
